// File: rtl/core/cssc_pkg.sv
// Shared constants, widths and helpers of the cosine similarity stream core.
package cssc_pkg;

   localparam int MAX_LEN   = 4096;
   localparam int ELEM_BITS = 16;

   localparam int ELEM_W  = 16;              // width of one element field
   localparam int SIM_W   = 16;              // width of the similarity field
   localparam int DOT_W   = 45;              // signed dot product sum
   localparam int SQ_W    = 44;              // unsigned sums of squares
   localparam int ACC_W   = 47;              // saturating adder width
   localparam int MUL_W   = 23;              // signed multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUB_W   = 46;              // compare and subtract width
   localparam int ROOT_W  = (SQ_W + 1) / 2;  // bits of a floor square root
   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = SIM_W - 1;
   localparam int CNT_W   = $clog2(ROOT_STEPS);

   localparam int SQ_SHIFT = 2 * ELEM_BITS - 2;
   localparam longint unsigned STATE_CAP = (64'd1 << SQ_W) - 64'd1;
   localparam longint unsigned FULL_SUM  = 64'(MAX_LEN) << SQ_SHIFT;
   localparam longint unsigned ACC_LIMIT =
      (SQ_SHIFT >= SQ_W) ? STATE_CAP : ((FULL_SUM > STATE_CAP) ? STATE_CAP : FULL_SUM);

   localparam logic [DIV_STEPS-1:0] Q_FULL_SCALE = '1;

   // Interpret the low ELEM_BITS bits of a field as a two's complement value.
   function automatic logic signed [ELEM_W-1:0] sext_elem(input logic [ELEM_W-1:0] raw);
      logic signed [ELEM_W-1:0] v;
      v = signed'(raw << (ELEM_W - ELEM_BITS));
      return v >>> (ELEM_W - ELEM_BITS);
   endfunction

endpackage

// File: rtl/core/cssc_req_if.sv
// Element pair channel of the cosine similarity stream core.
interface cssc_req_if import cssc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] element_a;
   logic signed [ELEM_W-1:0] element_b;
   logic                     last_element;

   modport source (output valid, element_a, element_b, last_element, input ready);
   modport sink   (input valid, element_a, element_b, last_element, output ready);
endinterface

// File: rtl/core/cssc_rsp_if.sv
// Result channel of the cosine similarity stream core.
interface cssc_rsp_if import cssc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [SIM_W-1:0] similarity;
   logic                    degenerate;

   modport source (output valid, similarity, degenerate, input ready);
   modport sink   (input valid, similarity, degenerate, output ready);
endinterface

// File: rtl/core/cssc_mul.sv
// Registered signed multiplier shared by every product of the core.
module cssc_mul import cssc_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

// File: rtl/core/cosine_similarity_stream_core.sv
// Top level of the streaming cosine similarity core.
//
// The req channel carries one element pair per beat: element_a, element_b and
// last_element. Each pair is folded into three running sums (dot product and
// the two sums of squares) by one shared multiplier and one saturating adder.
// Ready drops after the accepting edge and stays low while the sequencer
// steps through MUL_AB, MUL_AA, MUL_BB and ACC_BB, so no new pair is taken
// before it returns to idle. The sums saturate at the magnitude that MAX_LEN
// full-scale elements reach. On a pair marked last the core takes both floor
// square roots on one shared compare and subtract unit, multiplies them, and
// runs a 15-step restoring division, which is skipped when a norm is zero or
// the quotient clamps. Rsp valid rises from S_FINISH once the output
// register is free. The rsp channel then carries similarity in signed Q1.15
// (clamped to +/-32767) and degenerate, which is set with similarity zero
// when a norm is zero. The sums are cleared as the result is registered.
// The result waits in an output register, so the next vector's pairs are
// accepted while the receiver stalls; only a second result that finds the
// output register still full holds the core until that beat is taken.
// Synchronous reset clears the sums, returns the sequencer to idle and
// drops rsp valid.
module cosine_similarity_stream_core import cssc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   cssc_req_if.sink   req_chan,
   cssc_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_AB,
      S_MUL_AA,
      S_MUL_BB,
      S_ACC_BB,
      S_ROOT_A,
      S_ROOT_B,
      S_MUL_DEN,
      S_WAIT_DEN,
      S_DIV_SETUP,
      S_DIV,
      S_FINISH
   } state_type;

   localparam logic signed [ACC_W-1:0] LIM = ACC_W'(ACC_LIMIT);

   state_type state_ff, state_in;

   logic signed [ELEM_W-1:0]  elem_a_ff, elem_a_in;
   logic signed [ELEM_W-1:0]  elem_b_ff, elem_b_in;
   logic                      last_ff, last_in;
   logic signed [DOT_W-1:0]   dot_ff, dot_in;
   logic [SQ_W-1:0]           sqa_ff, sqa_in;
   logic [SQ_W-1:0]           sqb_ff, sqb_in;
   logic [SUB_W-1:0]          work_ff, work_in;
   logic [SUB_W-1:0]          res_ff, res_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ROOT_W-1:0]         root_a_ff, root_a_in;
   logic [SQ_W-1:0]           denom_ff, denom_in;
   logic [DIV_STEPS-1:0]      quot_ff, quot_in;
   logic                      degen_ff, degen_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SIM_W-1:0]   sim_ff, sim_in;
   logic                      rsp_degen_ff, rsp_degen_in;

   // Shared multiplier.
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   cssc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // Shared saturating adder, and shared compare and subtract unit.
   logic signed [ACC_W-1:0] acc_sel, acc_sum, acc_sat;
   logic [SUB_W-1:0]        sub_lhs, sub_rhs, root_bit, mag;
   logic [SUB_W:0]          sub_diff;
   logic                    sub_ge;
   logic signed [SUB_W-1:0] dot_ext;
   logic                    out_free;

   assign root_bit = SUB_W'(1) << {cnt_ff, 1'b0};
   assign dot_ext  = SUB_W'(dot_ff);
   assign mag      = dot_ff[DOT_W-1] ? unsigned'(-dot_ext) : unsigned'(dot_ext);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_AB: begin
            mul_a = MUL_W'(elem_a_ff);
            mul_b = MUL_W'(elem_b_ff);
         end
         S_MUL_AA: begin
            mul_a = MUL_W'(elem_a_ff);
            mul_b = MUL_W'(elem_a_ff);
         end
         S_MUL_BB: begin
            mul_a = MUL_W'(elem_b_ff);
            mul_b = MUL_W'(elem_b_ff);
         end
         S_MUL_DEN: begin
            mul_a = signed'(MUL_W'(root_a_ff));
            mul_b = signed'(MUL_W'(res_ff[ROOT_W-1:0]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         S_MUL_AA: acc_sel = ACC_W'(dot_ff);
         S_MUL_BB: acc_sel = signed'(ACC_W'(sqa_ff));
         S_ACC_BB: acc_sel = signed'(ACC_W'(sqb_ff));
         default:  acc_sel = '0;
      endcase
      acc_sum = acc_sel + ACC_W'(prod);
      if (acc_sum > LIM) begin
         acc_sat = LIM;
      end else if (acc_sum < -LIM) begin
         acc_sat = -LIM;
      end else begin
         acc_sat = acc_sum;
      end
   end

   always_comb begin
      case (state_ff)
         S_ROOT_A, S_ROOT_B: begin
            sub_lhs = work_ff;
            sub_rhs = res_ff + root_bit;
         end
         S_DIV_SETUP: begin
            sub_lhs = mag;
            sub_rhs = SUB_W'(denom_ff);
         end
         S_DIV: begin
            sub_lhs = {work_ff[SUB_W-2:0], 1'b0};
            sub_rhs = SUB_W'(denom_ff);
         end
         default: begin
            sub_lhs = '0;
            sub_rhs = '0;
         end
      endcase
      sub_diff = {1'b0, sub_lhs} - {1'b0, sub_rhs};
      sub_ge   = !sub_diff[SUB_W];
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.similarity = sim_ff;
   assign rsp_chan.degenerate = rsp_degen_ff;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      elem_a_in    = elem_a_ff;
      elem_b_in    = elem_b_ff;
      last_in      = last_ff;
      dot_in       = dot_ff;
      sqa_in       = sqa_ff;
      sqb_in       = sqb_ff;
      work_in      = work_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      root_a_in    = root_a_ff;
      denom_in     = denom_ff;
      quot_in      = quot_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sim_in       = sim_ff;
      rsp_degen_in = rsp_degen_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               elem_a_in = sext_elem(req_chan.element_a);
               elem_b_in = sext_elem(req_chan.element_b);
               last_in   = req_chan.last_element;
               state_in  = S_MUL_AB;
            end
         end
         S_MUL_AB: state_in = S_MUL_AA;
         S_MUL_AA: begin
            dot_in   = acc_sat[DOT_W-1:0];
            state_in = S_MUL_BB;
         end
         S_MUL_BB: begin
            sqa_in   = unsigned'(acc_sat[SQ_W-1:0]);
            state_in = S_ACC_BB;
         end
         S_ACC_BB: begin
            sqb_in = unsigned'(acc_sat[SQ_W-1:0]);
            if (last_ff) begin
               work_in  = SUB_W'(sqa_ff);
               res_in   = '0;
               cnt_in   = CNT_W'(ROOT_STEPS - 1);
               state_in = S_ROOT_A;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ROOT_A, S_ROOT_B: begin
            if (sub_ge) begin
               work_in = sub_diff[SUB_W-1:0];
               res_in  = (res_ff >> 1) + root_bit;
            end else begin
               res_in  = res_ff >> 1;
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (state_ff == S_ROOT_A) begin
                  // First root is done; start the second from a clean slate.
                  root_a_in = res_in[ROOT_W-1:0];
                  work_in   = SUB_W'(sqb_ff);
                  res_in    = '0;
                  cnt_in    = CNT_W'(ROOT_STEPS - 1);
                  state_in  = S_ROOT_B;
               end else begin
                  state_in  = S_MUL_DEN;
               end
            end
         end
         S_MUL_DEN:  state_in = S_WAIT_DEN;
         S_WAIT_DEN: begin
            denom_in = unsigned'(prod[SQ_W-1:0]);
            state_in = S_DIV_SETUP;
         end
         S_DIV_SETUP: begin
            quot_in  = '0;
            degen_in = 1'b0;
            if (denom_ff == '0) begin
               degen_in = 1'b1;
               state_in = S_FINISH;
            end else if (sub_ge) begin
               // The magnitude reaches the denominator: the quotient is at
               // least full scale and clamps.
               quot_in  = Q_FULL_SCALE;
               state_in = S_FINISH;
            end else begin
               work_in  = mag;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            quot_in = {quot_ff[DIV_STEPS-2:0], sub_ge};
            work_in = sub_ge ? sub_diff[SUB_W-1:0] : sub_lhs;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_degen_in = degen_ff;
               sim_in       = dot_ff[DOT_W-1] ? -signed'({1'b0, quot_ff})
                                              : signed'({1'b0, quot_ff});
               dot_in       = '0;
               sqa_in       = '0;
               sqb_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dot_ff       <= '0;
         sqa_ff       <= '0;
         sqb_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dot_ff       <= dot_in;
         sqa_ff       <= sqa_in;
         sqb_ff       <= sqb_in;
      end
      elem_a_ff    <= elem_a_in;
      elem_b_ff    <= elem_b_in;
      last_ff      <= last_in;
      work_ff      <= work_in;
      res_ff       <= res_in;
      cnt_ff       <= cnt_in;
      root_a_ff    <= root_a_in;
      denom_ff     <= denom_in;
      quot_ff      <= quot_in;
      degen_ff     <= degen_in;
      sim_ff       <= sim_in;
      rsp_degen_ff <= rsp_degen_in;
   end

endmodule

// File: rtl/core/cssc_checker.sv
// Port-level checks of the cosine similarity stream core and their bind.
module cssc_checker import cssc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [SIM_W-1:0] similarity,
   input logic                    degenerate
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(similarity) && $stable(degenerate))
      else $error("result payload changed while stalled");

   // A zero norm always comes with a zero similarity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> similarity == '0)
      else $error("degenerate result with nonzero similarity");

   // The clamp keeps the most negative code out of the output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> similarity != {1'b1, {(SIM_W - 1){1'b0}}})
      else $error("similarity outside the clamped range");

   // Each accepted pair keeps the sequencer busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pair accepted while the previous one was still in work");

endmodule

bind cosine_similarity_stream_core cssc_checker u_cssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .similarity (rsp_chan.similarity),
   .degenerate (rsp_chan.degenerate)
);

// File: tb/sv/cosine_similarity_stream_core_tb.sv
// Self-checking testbench of the streaming cosine similarity core.
module cosine_similarity_stream_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cssc_pkg::*;

   // Run control. The drain after the final expected result is sized above the time a vector
   // takes after its last pair; the quiet-cycle watchdog is sized well above that and above
   // the long receiver hold-off.
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 600;
   localparam int PHASE_ITEMS    = 184;
   localparam int FULL_SCALE     = 32767;

   // Saturation bound of the three sums: what MAX_LEN full-scale elements reach, but never
   // more than the 44-bit width of the sums of squares can hold.
   localparam longint unsigned WIDTH_CAP = (64'd1 << SQ_W) - 64'd1;
   localparam longint unsigned LEN_CAP   =
      (2 * ELEM_BITS - 2 >= SQ_W) ? WIDTH_CAP : (64'(MAX_LEN) << (2 * ELEM_BITS - 2));
   localparam longint unsigned SUM_LIMIT = (LEN_CAP > WIDTH_CAP) ? WIDTH_CAP : LEN_CAP;

   typedef struct packed {
      logic signed [SIM_W-1:0] similarity;
      logic                    degenerate;
   } sim_result_type;

   // One row of the directed table. A row repeats its pair reps times; last_element is set
   // only on the final repetition. Where typed is set, the expected result is the one
   // written in the row rather than the one the predictor works out.
   typedef struct {
      logic signed [ELEM_W-1:0] elem_a;
      logic signed [ELEM_W-1:0] elem_b;
      int                       reps;
      logic                     last;
      bit                       typed;
      logic signed [SIM_W-1:0]  exp_sim;
      logic                     exp_degen;
   } stim_row_type;

   // Shapes of the random vectors.
   typedef enum int {
      STYLE_FULL,
      STYLE_SMALL,
      STYLE_EXTREME,
      STYLE_MATCHED,
      STYLE_OPPOSED,
      STYLE_ZERO_A,
      STYLE_ZERO_B,
      STYLE_COUNT
   } vec_style_type;

   localparam int DIRECTED_ROWS = 24;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // A zero vector right after reset is degenerate.
      '{0, 0, 1, 1, 1, 0, 1},
      // Single full-scale pairs: the floor roots make the quotient reach 32768, which
      // is clamped to full scale with the sign of the dot product.
      '{32767, 32767, 1, 1, 1, 32767, 0},
      '{-32768, -32768, 1, 1, 1, 32767, 0},
      '{-32768, 32767, 1, 1, 1, -32767, 0},
      '{32767, -32768, 1, 1, 1, -32767, 0},
      // One side zero makes the vector degenerate.
      '{0, 12345, 1, 1, 1, 0, 1},
      '{-7, 0, 1, 1, 1, 0, 1},
      // Smallest nonzero magnitudes.
      '{1, 1, 1, 1, 1, 32767, 0},
      '{1, -1, 1, 1, 1, -32767, 0},
      // Orthogonal unit vectors give zero without the degenerate flag.
      '{1, 0, 1, 0, 0, 0, 0},
      '{0, 1, 1, 1, 1, 0, 0},
      // A longer vector of zeros is still degenerate.
      '{0, 0, 3, 0, 0, 0, 0},
      '{0, 0, 1, 1, 1, 0, 1},
      // Short vectors left to the predictor, one of them with rounding slack.
      '{3, 4, 1, 0, 0, 0, 0},
      '{4, -3, 1, 1, 0, 0, 0},
      '{2, 3, 1, 0, 0, 0, 0},
      '{3, 2, 1, 1, 0, 0, 0},
      // Alternating bit patterns.
      '{21845, -21846, 1, 0, 0, 0, 0},
      '{-21846, 21845, 1, 1, 0, 0, 0},
      // Overlong vectors: every sum saturates and the result is clamped to full scale. Short ones follow.
      '{-32768, -32768, 4100, 1, 1, 32767, 0},
      '{-32768, 32767, 4100, 1, 1, -32767, 0},
      '{100, -50, 2, 0, 0, 0, 0},
      '{-3, 9, 1, 1, 0, 0, 0},
      '{12345, -23456, 1, 1, 0, 0, 0}
   };

   logic clock;
   logic reset;

   cssc_req_if req_chan ();
   cssc_rsp_if rsp_chan ();

   cosine_similarity_stream_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: the running sums at the block's own widths.
   logic signed [DOT_W-1:0] dot_acc;
   logic [SQ_W-1:0]         energy_a;
   logic [SQ_W-1:0]         energy_b;

   sim_result_type pending_results [$];
   int             mismatch_count;
   int             tx_idle_pct;
   int             rx_idle_pct;
   bit             stall_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Floor square root, built one result bit at a time from the top.
   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 23; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   function automatic longint unsigned clamp_energy(input longint unsigned sum);
      return (sum > SUM_LIMIT) ? SUM_LIMIT : sum;
   endfunction

   // Folds one pair into the sums. On the last pair it also works out the similarity and
   // clears the sums.
   function automatic void fold_pair(input logic signed [ELEM_W-1:0] a,
                                     input logic signed [ELEM_W-1:0] b,
                                     input logic last, output bit produced,
                                     output sim_result_type res);
      longint          dot;
      longint          lim;
      longint          signed_q;
      longint unsigned sum_a;
      longint unsigned sum_b;
      longint unsigned denom;
      longint unsigned mag;
      longint unsigned quot;
      lim = longint'(SUM_LIMIT);
      dot = longint'(dot_acc) + longint'(a) * longint'(b);
      if (dot > lim) dot = lim;
      else if (dot < -lim) dot = -lim;
      sum_a = clamp_energy(64'(energy_a) + 64'(longint'(a) * longint'(a)));
      sum_b = clamp_energy(64'(energy_b) + 64'(longint'(b) * longint'(b)));
      dot_acc  = dot[DOT_W-1:0];
      energy_a = sum_a[SQ_W-1:0];
      energy_b = sum_b[SQ_W-1:0];
      produced = last;
      res = '0;
      if (last) begin
         denom = floor_root(sum_a) * floor_root(sum_b);
         if (denom == 0) begin
            res.degenerate = 1'b1;
         end else begin
            mag = (dot < 0) ? -dot : dot;
            quot = (mag << 15) / denom;
            if (quot > FULL_SCALE) quot = FULL_SCALE;
            signed_q = (dot < 0) ? -longint'(quot) : longint'(quot);
            res.similarity = signed_q[SIM_W-1:0];
         end
         dot_acc  = '0;
         energy_a = '0;
         energy_b = '0;
      end
   endfunction

   // Offers one pair at a falling edge, after a random number of idle cycles, and holds it
   // until the core takes the beat. The accepted pair goes through the predictor at once.
   task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b, input logic last,
                            input bit use_typed, input sim_result_type typed);
      bit             produced;
      sim_result_type res;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.element_a    <= a;
      req_chan.element_b    <= b;
      req_chan.last_element <= last;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      fold_pair(a, b, last, produced, res);
      if (produced) pending_results.push_back(use_typed ? typed : res);
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic pause_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_extreme();
      case ($urandom_range(4))
         0: return -32768;
         1: return 32767;
         2: return 1;
         3: return -1;
         default: return 0;
      endcase
   endfunction

   // Receiver. It normally lowers ready at random; on request it holds ready low for a
   // long stretch, counted here, so the core fills up and stalls the element stream.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            hold_left = LONG_HOLD;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Result checker: each beat is compared with the oldest expectation.
   always @(posedge clock) begin
      sim_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation: similarity %0d, degenerate %0b",
                   rsp_chan.similarity, rsp_chan.degenerate);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.similarity !== want.similarity) begin
               $error("similarity mismatch: expected %0d, got %0d",
                      want.similarity, rsp_chan.similarity);
               mismatch_count++;
            end
            if (rsp_chan.degenerate !== want.degenerate) begin
               $error("degenerate mismatch: expected %0b, got %0b",
                      want.degenerate, rsp_chan.degenerate);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles in a row without a beat on either channel ends the run.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int                       phase_items;
      int                       vec_len;
      vec_style_type            style;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      sim_result_type           typed;

      // Every input is known from time zero.
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.element_a    = '0;
      req_chan.element_b    = '0;
      req_chan.last_element = 1'b0;
      stall_request         = 1'b0;
      mismatch_count        = 0;
      tx_idle_pct           = 27;
      rx_idle_pct           = 78;
      dot_acc               = '0;
      energy_a              = '0;
      energy_b              = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table row by row.
      foreach (directed_rows[r]) begin
         typed.similarity = directed_rows[r].exp_sim;
         typed.degenerate = directed_rows[r].exp_degen;
         for (int rep = 0; rep < directed_rows[r].reps; rep++) begin
            send_pair(directed_rows[r].elem_a, directed_rows[r].elem_b,
                      directed_rows[r].last && (rep == directed_rows[r].reps - 1),
                      directed_rows[r].typed, typed);
         end
      end

      // Random part in three idling phases. Each phase starts with the sender paused until
      // every expected result has come back.
      for (int phase = 0; phase < 3; phase++) begin
         pause_until_drained();
         case (phase)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 78;
            end
            1: begin
               tx_idle_pct = 78;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // Mostly short vectors, now and then a longer one.
            vec_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            style = vec_style_type'($urandom_range(STYLE_COUNT - 1));
            for (int k = 0; k < vec_len; k++) begin
               a = ELEM_W'($urandom);
               b = ELEM_W'($urandom);
               case (style)
                  STYLE_SMALL: begin
                     a = ELEM_W'($signed($urandom_range(8)) - 4);
                     b = ELEM_W'($signed($urandom_range(8)) - 4);
                  end
                  STYLE_EXTREME: begin
                     a = pick_extreme();
                     b = pick_extreme();
                  end
                  STYLE_MATCHED: b = a;
                  STYLE_OPPOSED: b = -a;
                  STYLE_ZERO_A:  a = 0;
                  STYLE_ZERO_B:  b = 0;
                  default: ;
               endcase
               if ($urandom_range(15) == 0) a = pick_extreme();
               send_pair(a, b, k == vec_len - 1, 1'b0, '0);
               phase_items++;
               // With nobody idling, the receiver now holds off for a long stretch while
               // the sender keeps offering pairs.
               if (phase == 2 && phase_items == 40) stall_request = 1'b1;
            end
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/cssc_pkg.sv
rtl/core/cssc_req_if.sv
rtl/core/cssc_rsp_if.sv
rtl/core/cssc_mul.sv
rtl/core/cosine_similarity_stream_core.sv
rtl/core/cssc_checker.sv
tb/sv/cosine_similarity_stream_core_tb.sv
